[design/pic_pkg.sv]
package pic_pkg;

    localparam int ERR_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int DRIVE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P   = 2'd0,
        REG_GAIN_I   = 2'd1,
        REG_SETPOINT = 2'd2
    } cfg_reg_t;

    // load strobes for the two multiply/output stages
    typedef struct packed {
        logic ld_prod;
        logic ld_out;
    } mac_ctl_t;

    // clamp a 17-bit difference into 16-bit signed range
    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ERR_W:0] d);
        logic signed [ERR_W-1:0] r;
        begin
            if (d[ERR_W] != d[ERR_W-1])
            begin
                r = d[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
            end
            else
            begin
                r = d[ERR_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

[design/pic_ram.sv]
module pic_ram #(
    parameter int DEPTH = 100,
    parameter int AW    = 7,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    // read-first: the word coming out is the one being replaced
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg     <= mem_reg[addr];
            mem_reg[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/pic_mac.sv]
module pic_mac #(
    parameter int SUM_W = 23
) (
    input  logic                                        clk,
    input  pic_pkg::mac_ctl_t                           ctl,
    input  logic signed [pic_pkg::GAIN_W-1:0]           gain_p,
    input  logic signed [pic_pkg::GAIN_W-1:0]           gain_i,
    input  logic signed [pic_pkg::ERR_W-1:0]            err_in,
    input  logic signed [SUM_W-1:0]                     sum_in,
    output logic signed [pic_pkg::DRIVE_W-1:0]          drive,
    output logic signed [pic_pkg::ERR_W-1:0]            err_out
);
    import pic_pkg::*;

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + SUM_W;
    localparam int ACC_W = (PI_W + 1 > DRIVE_W + FRAC_BITS + 1) ? PI_W + 1
                                                                : DRIVE_W + FRAC_BITS + 1;
    localparam int SH_W  = ACC_W - FRAC_BITS;

    logic signed [PP_W-1:0]    prod_p_reg;
    logic signed [PI_W-1:0]    prod_i_reg;
    logic signed [ERR_W-1:0]   err3_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [ERR_W-1:0]   err4_reg;

    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_sh;
    logic        [SH_W-1:0]    sh;
    logic signed [DRIVE_W-1:0] drive_next;

    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            prod_p_reg <= gain_p * err_in;
            prod_i_reg <= gain_i * sum_in;
            err3_reg   <= err_in;
        end
    end

    assign acc    = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg);
    assign acc_sh = acc >>> FRAC_BITS;
    assign sh     = acc_sh[SH_W-1:0];

    // floor shift then clamp: upper bits must all match the sign
    always_comb
    begin
        if (!sh[SH_W-1] && (|sh[SH_W-2:DRIVE_W-1]))
        begin
            drive_next = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
        else if (sh[SH_W-1] && !(&sh[SH_W-2:DRIVE_W-1]))
        begin
            drive_next = {1'b1, {(DRIVE_W-1){1'b0}}};
        end
        else
        begin
            drive_next = sh[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_out)
        begin
            drive_reg <= drive_next;
            err4_reg  <= err3_reg;
        end
    end

    assign drive   = drive_reg;
    assign err_out = err4_reg;

endmodule

[design/windowed_integral_pi_controller.sv]
// PI controller with a sliding-window integral. Each measured word gives one
// result word: error_now = setpoint - measured (saturated to 16 bits) and
// drive = (gain_p*error + gain_i*sum of the last WINDOW errors) >> 8, floored
// and saturated to 32 bits. One word is taken every clock cycle while the output
// is not stalled. Its result is registered through the window read, running sum,
// products and clamped drive output register stages. The rate is set by the
// single-port error window memory, which is read and rewritten at the same slot
// in the cycle a word is accepted, while the running sum is updated when the word
// leaves the window read stage. A waiting result stalls input once every stage
// holds a word. Window slots not yet written since reset count as zero through a
// fill flag, so the block is ready right after reset with no clearing pass.
// Gains and setpoint must be written only while the block is idle.
module windowed_integral_pi_controller #(
    parameter int WINDOW = 100
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pic_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pic_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [pic_pkg::ERR_W-1:0]       measured,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [pic_pkg::DRIVE_W-1:0]     drive,
    output logic signed [pic_pkg::ERR_W-1:0]       error_now
);
    import pic_pkg::*;

    localparam int PTR_W = $clog2(WINDOW);
    localparam int SUM_W = PTR_W + ERR_W;

    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [ERR_W-1:0]  setpoint_reg;

    logic [PTR_W-1:0]         ptr_reg;
    logic                     fill_reg;

    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic                     v4_reg;
    logic signed [ERR_W-1:0]  err1_reg;
    logic                     old_ok1_reg;
    logic signed [ERR_W-1:0]  err2_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    logic                     free1;
    logic                     free2;
    logic                     free3;
    logic                     free4;
    logic                     accept;
    logic                     mv12;
    logic signed [ERR_W:0]    diff;
    logic signed [ERR_W-1:0]  err0;
    logic        [ERR_W-1:0]  rd_word;
    logic signed [ERR_W-1:0]  old_err;
    mac_ctl_t                 mac_ctl;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= 16'sd256;
            gain_i_reg   <= 16'sd256;
            setpoint_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:   gain_p_reg   <= $signed(cfg_data);
                REG_GAIN_I:   gain_i_reg   <= $signed(cfg_data);
                REG_SETPOINT: setpoint_reg <= $signed(cfg_data);
                default:      ;
            endcase
        end
    end

    // stage k may load when empty or when its word moves on
    assign free4    = !v4_reg || out_ready;
    assign free3    = !v3_reg || free4;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign in_ready = free1;
    assign accept   = in_valid && free1;
    assign mv12     = v1_reg && free2;

    assign diff = {setpoint_reg[ERR_W-1], setpoint_reg} - {measured[ERR_W-1], measured};
    assign err0 = sat_err(diff);

    pic_ram #(
        .DEPTH (WINDOW),
        .AW    (PTR_W),
        .DW    (ERR_W)
    ) u_ram (
        .clk   (clk),
        .en    (accept),
        .addr  (ptr_reg),
        .wdata (err0),
        .rdata (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            fill_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (ptr_reg == PTR_W'(WINDOW - 1))
            begin
                ptr_reg  <= '0;
                fill_reg <= 1'b1;
            end
            else
            begin
                ptr_reg <= ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= in_valid;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
            if (free4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err1_reg    <= err0;
            old_ok1_reg <= fill_reg;
        end
        if (mv12)
        begin
            err2_reg <= err1_reg;
        end
    end

    // slot not yet written since reset reads as zero
    assign old_err  = old_ok1_reg ? $signed(rd_word) : '0;
    assign sum_next = sum_reg - SUM_W'(old_err) + SUM_W'(err1_reg);

    // sum_reg doubles as stage 2 payload: it only changes when stage 2 reloads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (mv12)
        begin
            sum_reg <= sum_next;
        end
    end

    assign mac_ctl.ld_prod = v2_reg && free3;
    assign mac_ctl.ld_out  = v3_reg && free4;

    pic_mac #(
        .SUM_W (SUM_W)
    ) u_mac (
        .clk     (clk),
        .ctl     (mac_ctl),
        .gain_p  (gain_p_reg),
        .gain_i  (gain_i_reg),
        .err_in  (err2_reg),
        .sum_in  (sum_reg),
        .drive   (drive),
        .err_out (error_now)
    );

    assign out_valid = v4_reg;

endmodule

[design/pic_checker.sv]
module pic_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [pic_pkg::DRIVE_W-1:0]  drive,
    input logic signed [pic_pkg::ERR_W-1:0]    error_now
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(error_now))
        else $error("result word changed while stalled");

    // a free output stage means the whole pipe can move
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with output stage free");

    // a rising result valid must trace back to an accepted word
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 4))
        else $error("result word without matching input word");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("out_valid high in reset");

endmodule

bind windowed_integral_pi_controller pic_checker u_pic_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .error_now (error_now)
);

[test/pi_drive_monitor.sv]
module pi_drive_monitor #(
    parameter int WINDOW = 100
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pic_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pic_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [pic_pkg::ERR_W-1:0]     measured,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [pic_pkg::DRIVE_W-1:0]   drive,
    input  logic signed [pic_pkg::ERR_W-1:0]     error_now,
    output int                                   mismatches,
    output int                                   pending,
    output int                                   compared
);
    timeunit 1ns;
    timeprecision 1ps;

    import pic_pkg::*;

    localparam int     ERR_MAX   = (1 << (ERR_W - 1)) - 1;
    localparam int     ERR_MIN   = -(1 << (ERR_W - 1));
    localparam longint DRIVE_MAX = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_MIN = -(longint'(1) <<< (DRIVE_W - 1));

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [ERR_W-1:0]   err;
    } ctl_word_t;

    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [ERR_W-1:0]  target;
    logic signed [ERR_W-1:0]  err_hist [WINDOW];
    int                       slot;
    int                       win_sum;
    ctl_word_t                drive_due [$];
    ctl_word_t                due;
    int                       fail_cnt;
    int                       match_cnt;

    // one control step: error into the window, drive from the windowed sum
    task automatic predict_drive(input logic signed [ERR_W-1:0] meas, output ctl_word_t res);
        int     diff;
        longint acc;
        diff = int'(target) - int'(meas);
        if (diff > ERR_MAX)
            diff = ERR_MAX;
        else if (diff < ERR_MIN)
            diff = ERR_MIN;
        win_sum = win_sum - int'(err_hist[slot]) + diff;
        err_hist[slot] = diff[ERR_W-1:0];
        slot = (slot + 1) % WINDOW;
        acc = longint'(kp) * diff + longint'(ki) * win_sum;
        acc = acc >>> FRAC_BITS;    // arithmetic shift floors
        if (acc > DRIVE_MAX)
            acc = DRIVE_MAX;
        else if (acc < DRIVE_MIN)
            acc = DRIVE_MIN;
        res.drive = acc[DRIVE_W-1:0];
        res.err   = diff[ERR_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp     = GAIN_W'(1 << FRAC_BITS);
            ki     = GAIN_W'(1 << FRAC_BITS);
            target = '0;
            foreach (err_hist[i])
                err_hist[i] = '0;
            slot      = 0;
            win_sum   = 0;
            drive_due.delete();
            fail_cnt  = 0;
            match_cnt = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_GAIN_P:   kp = cfg_data;
                    REG_GAIN_I:   ki = cfg_data;
                    REG_SETPOINT: target = cfg_data;
                    default: ;  // unmapped index, write dropped
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_drive(measured, due);
                drive_due.push_back(due);
            end
            if (out_valid && out_ready)
            begin
                if (drive_due.size() == 0)
                begin
                    fail_cnt++;
                    $error("drive: expected nothing, got %0d (error_now %0d)",
                           drive, error_now);
                end
                else
                begin
                    due = drive_due.pop_front();
                    match_cnt++;
                    if (drive !== due.drive)
                    begin
                        fail_cnt++;
                        $error("drive: expected %0d, got %0d", due.drive, drive);
                    end
                    if (error_now !== due.err)
                    begin
                        fail_cnt++;
                        $error("error_now: expected %0d, got %0d", due.err, error_now);
                    end
                end
            end
        end
        mismatches <= fail_cnt;
        pending    <= drive_due.size();
        compared   <= match_cnt;
    end

endmodule

[test/tb_windowed_integral_pi_controller.sv]
module tb_windowed_integral_pi_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import pic_pkg::*;

    localparam int                   WINDOW       = 100;
    localparam int                   STALL_LIMIT  = 2000;
    localparam int                   IDLE_PCT     = 26;
    localparam int                   RAND_PHASES  = 7;
    localparam int                   PHASE_WORDS  = 250;
    localparam int                   STEADY_PHASE = 3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [ERR_W-1:0]    measured;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [DRIVE_W-1:0]  drive;
    logic signed [ERR_W-1:0]    error_now;

    int                         mismatches;
    int                         pending;
    int                         compared;
    int                         words_sent;
    int                         settings_cnt;
    int                         stall_cycles;
    bit                         steady;
    int                         plant;
    logic signed [ERR_W-1:0]    sp_now;

    windowed_integral_pi_controller #(
        .WINDOW(WINDOW)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .measured  (measured),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .error_now (error_now)
    );

    pi_drive_monitor #(
        .WINDOW(WINDOW)
    ) drive_mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .measured   (measured),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive      (drive),
        .error_now  (error_now),
        .mismatches (mismatches),
        .pending    (pending),
        .compared   (compared)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // watchdog: any accepted word on either side restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic [CFG_DATA_W-1:0] rnd16();
        return CFG_DATA_W'($urandom());
    endfunction

    task automatic push_measured(input logic signed [ERR_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        measured <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // lower valid and hold off until every result is out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] gp,
                                 input logic [CFG_DATA_W-1:0] gi,
                                 input logic [CFG_DATA_W-1:0] sp,
                                 input bit poke_unused);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAIN_P;
        cfg_data  <= gp;
        @(posedge clk);
        cfg_index <= REG_GAIN_I;
        cfg_data  <= gi;
        @(posedge clk);
        cfg_index <= REG_SETPOINT;
        cfg_data  <= sp;
        @(posedge clk);
        if (poke_unused)
        begin
            cfg_index <= REG_UNUSED;
            cfg_data  <= rnd16();
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        sp_now = sp;
        settings_cnt++;
    endtask

    initial
    begin
        logic signed [ERR_W-1:0] meas;
        int                      pick;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_GAIN_P;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        measured     <= '0;
        steady       = 1'b0;
        words_sent   = 0;
        settings_cnt = 0;
        plant        = 0;
        sp_now       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: field extremes and alternating bit patterns
        push_measured(16'sh8000);
        push_measured(16'sh7fff);
        push_measured(16'sh0000);
        push_measured(-16'sd1);
        push_measured(16'sd1);
        push_measured(16'sh5555);
        push_measured(16'shaaaa);
        drain_results();

        // error clamps high; unmapped index must leave the gains alone
        load_settings(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
        repeat (4) push_measured(16'sh8000);
        push_measured(16'sh7fff);
        push_measured(16'sh0000);
        drain_results();

        // error clamps low with most negative gains
        load_settings(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        repeat (4) push_measured(16'sh7fff);
        push_measured(16'sh8000);
        push_measured(16'sd1);
        drain_results();

        load_settings(16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
        push_measured(16'sd12345);
        push_measured(-16'sd12345);
        drain_results();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: load_settings(16'sh7fff, 16'sh8000, rnd16(), 1'b0);
                1: load_settings(16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1);
                2: load_settings(16'sd256, 16'sd256, 16'sh8000, 1'b0);
                default: load_settings(rnd16(), rnd16(), rnd16(), ph == 5);
            endcase
            steady = (ph == STEADY_PHASE);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    // crude first-order plant chasing the setpoint, plus noise
                    plant = plant + ((int'(sp_now) - plant) >>> 3)
                            + int'($urandom_range(0, 64)) - 32;
                    if (plant > 32767)
                        plant = 32767;
                    else if (plant < -32768)
                        plant = -32768;
                    meas = plant[ERR_W-1:0];
                end
                else if (pick < 80)
                begin
                    meas = rnd16();
                end
                else if (pick < 92)
                begin
                    case ($urandom_range(0, 3))
                        0: meas = 16'sh8000;
                        1: meas = 16'sh7fff;
                        2: meas = 16'sh0000;
                        default: meas = -16'sd1;
                    endcase
                end
                else
                begin
                    meas = sp_now;
                end
                push_measured(meas);
            end
            drain_results();
            steady = 1'b0;
        end

        drain_results();
        repeat (12) @(posedge clk);
        $display("Sent %0d measured words under %0d gain/setpoint settings,",
                 words_sent, settings_cnt);
        $display("%0d drive/error words compared, incl. clamps and unmapped index",
                 compared);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
design/pic_pkg.sv
design/pic_ram.sv
design/pic_mac.sv
design/windowed_integral_pi_controller.sv
design/pic_checker.sv
test/pi_drive_monitor.sv
test/tb_windowed_integral_pi_controller.sv
